FILE: rtl/core/dtrt_pkg.sv
// ----------------------------------------------------------------------------
// dtrt_pkg
// Shared types and constants for the delayed task ready table.
// ----------------------------------------------------------------------------
package dtrt_pkg;

    // Field widths of the transfer payloads
    localparam int FUNC_W  = 2;
    localparam int SLOT_W  = 4;
    localparam int DELAY_W = 16;
    localparam int ID_W    = 4;

    // Default table size
    localparam int DEF_NUM_TASKS = 16;

    // Operation codes
    typedef enum logic [FUNC_W-1:0] {
        FUNC_QUEUE    = 2'd0,
        FUNC_UNQUEUE  = 2'd1,
        FUNC_TICK     = 2'd2,
        FUNC_DISPATCH = 2'd3
    } t_func;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINAL
    } t_state;

endpackage

FILE: rtl/core/delayed_task_ready_table.sv
// ----------------------------------------------------------------------------
// delayed_task_ready_table
// Task slot table with per-slot active flag and tick delay counter.
// ----------------------------------------------------------------------------
// A queue or unqueue is taken in the idle state and returns one acknowledge
// result. A tick or a dispatch sweeps the delay memory one slot per cycle,
// with a dispatch sweep held while the output is stalled, through its single
// read and single write port. It holds the input stalled through the sweep
// and until its final result is loaded into the output register. A dispatch
// returns one result per ready slot in ascending slot order, last marked on
// the final one, or a single result with ready clear if no slot is ready.
// Active flags sit in flip-flops and clear at reset; the delay memory needs no
// clearing because a slot only becomes active through a queue that writes it.
// ----------------------------------------------------------------------------
module delayed_task_ready_table #(
    parameter int NUM_TASKS = dtrt_pkg::DEF_NUM_TASKS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [dtrt_pkg::FUNC_W-1:0]  i_func,
    input  logic [dtrt_pkg::SLOT_W-1:0]  i_slot,
    input  logic [dtrt_pkg::DELAY_W-1:0] i_start_delay,
    // Output channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [dtrt_pkg::ID_W-1:0]    o_ready_id,
    output logic                         o_ready_res,
    output logic                         o_last
);
    import dtrt_pkg::*;

    localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CNT_W = $clog2(NUM_TASKS + 1);
    localparam logic [CNT_W-1:0] END_CNT = CNT_W'(NUM_TASKS);

    // Delay counter memory
    logic [DELAY_W-1:0] mem [NUM_TASKS];

    t_state               r_state, n_state;
    t_func                r_op;
    logic [NUM_TASKS-1:0] r_active;
    logic [CNT_W-1:0]     r_rd_idx;
    logic                 r_ev_vld;
    logic [IDX_W-1:0]     r_ev_idx;
    logic [DELAY_W-1:0]   r_rd_data;
    logic                 r_pend_vld;
    logic [ID_W-1:0]      r_pend_id;
    logic                 r_out_vld;
    logic [ID_W-1:0]      r_out_id;
    logic                 r_out_res;
    logic                 r_out_last;

    logic                 out_free;
    logic                 in_acc;
    t_func                in_func;
    logic                 slot_ok;
    logic [IDX_W-1:0]     slot_idx;
    logic                 advance;
    logic                 rd_more;
    logic                 sweep_done;
    logic                 ev_ready;
    logic                 mem_re;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [DELAY_W-1:0]   mem_wdata;
    logic                 emit;
    logic [ID_W-1:0]      emit_id;
    logic                 emit_res;
    logic                 emit_last;
    logic                 pend_load;
    logic                 pend_clr;
    logic                 act_set;
    logic                 act_clr;

    // Decode the incoming item
    assign out_free   = !r_out_vld || !i_stall;
    assign o_stall    = !((r_state == ST_IDLE) && out_free);
    assign in_acc     = i_valid && !o_stall;
    assign in_func    = t_func'(i_func);
    assign slot_ok    = (32'(i_slot) < NUM_TASKS);
    assign slot_idx   = IDX_W'(i_slot);
    assign rd_more    = (r_rd_idx < END_CNT);
    assign sweep_done = !r_ev_vld && !rd_more;
    assign advance    = (r_op == FUNC_TICK) || out_free;
    assign ev_ready   = r_ev_vld && r_active[r_ev_idx] && (r_rd_data == '0);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && (in_func == FUNC_TICK || in_func == FUNC_DISPATCH)) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (sweep_done) begin
                    n_state = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs: memory access, result emission, flag updates
    always_comb begin
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = r_ev_idx;
        mem_wdata = r_rd_data - DELAY_W'(1);
        emit      = 1'b0;
        emit_id   = '0;
        emit_res  = 1'b0;
        emit_last = 1'b1;
        pend_load = 1'b0;
        pend_clr  = 1'b0;
        act_set   = 1'b0;
        act_clr   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (in_func)
                        FUNC_QUEUE: begin
                            emit      = 1'b1;
                            act_set   = slot_ok;
                            mem_we    = slot_ok;
                            mem_waddr = slot_idx;
                            mem_wdata = i_start_delay;
                        end
                        FUNC_UNQUEUE: begin
                            emit    = 1'b1;
                            act_clr = slot_ok;
                        end
                        default: pend_clr = 1'b1;
                    endcase
                end
            end
            ST_SWEEP: begin
                if (advance) begin
                    mem_re = rd_more;
                    if (r_ev_vld && r_active[r_ev_idx]) begin
                        if (r_op == FUNC_TICK) begin
                            mem_we = (r_rd_data != '0);
                        end else if (ev_ready) begin
                            // push the previous ready slot, hold this one
                            emit      = r_pend_vld;
                            emit_id   = r_pend_id;
                            emit_res  = 1'b1;
                            emit_last = 1'b0;
                            pend_load = 1'b1;
                        end
                    end
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    emit     = 1'b1;
                    emit_id  = r_pend_vld ? r_pend_id : '0;
                    emit_res = r_pend_vld;
                    pend_clr = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Memory write and registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= mem[r_rd_idx[IDX_W-1:0]];
        end
    end

    // Sweep pipeline payload
    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_ev_idx <= r_rd_idx[IDX_W-1:0];
        end
        if (pend_load) begin
            r_pend_id <= ID_W'(r_ev_idx);
        end
        if (in_acc) begin
            r_op <= in_func;
        end
        if (emit) begin
            r_out_id   <= emit_id;
            r_out_res  <= emit_res;
            r_out_last <= emit_last;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_active   <= '0;
            r_rd_idx   <= '0;
            r_ev_vld   <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (act_set) begin
                r_active[slot_idx] <= 1'b1;
            end
            if (act_clr) begin
                r_active[slot_idx] <= 1'b0;
            end
            // advance the sweep counters
            if (in_acc) begin
                r_rd_idx <= '0;
                r_ev_vld <= 1'b0;
            end else if (r_state == ST_SWEEP && advance) begin
                r_ev_vld <= mem_re;
                if (mem_re) begin
                    r_rd_idx <= r_rd_idx + CNT_W'(1);
                end
            end
            if (pend_clr) begin
                r_pend_vld <= 1'b0;
            end else if (pend_load) begin
                r_pend_vld <= 1'b1;
            end
            // hold the result until its transfer
            if (emit) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_valid     = r_out_vld;
    assign o_ready_id  = r_out_id;
    assign o_ready_res = r_out_res;
    assign o_last      = r_out_last;

endmodule

FILE: rtl/core/dtrt_checker.sv
// ----------------------------------------------------------------------------
// dtrt_checker
// Port-level checks for the delayed task ready table, bound to the top level.
// ----------------------------------------------------------------------------
module dtrt_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_stall,
    input logic [dtrt_pkg::FUNC_W-1:0]  i_func,
    input logic [dtrt_pkg::SLOT_W-1:0]  i_slot,
    input logic [dtrt_pkg::DELAY_W-1:0] i_start_delay,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic [dtrt_pkg::ID_W-1:0]    o_ready_id,
    input logic                         o_ready_res,
    input logic                         o_last
);
    import dtrt_pkg::*;

    logic in_seen;
    assign in_seen = i_valid && (i_func <= FUNC_W'(FUNC_DISPATCH)) && (|{i_slot, i_start_delay}
                     || !(|{i_slot, i_start_delay}));

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_ready_id) && $stable(o_ready_res)
                               && $stable(o_last))
        else $error("stalled result changed");

    // A result without a ready slot is a lone final result naming slot zero
    a_ack_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ready_res |-> o_last && (o_ready_id == '0))
        else $error("acknowledge result malformed");

    // Take no new item while a result is blocked at the output
    a_block_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> o_stall)
        else $error("input taken while output blocked");

    // An item is taken only after the previous one has sent a final result
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_seen && !o_stall && o_valid && !o_last |-> 1'b0)
        else $error("item taken in the middle of a dispatch");

endmodule

bind delayed_task_ready_table dtrt_checker u_dtrt_checker (.*);
